// ----- hdl/shfr_pkg.sv -----
// Shared types, register indexes and constants of the sync-header frame receiver.
package shfr_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned LEN_W       = 3;

    localparam logic [BYTE_W-1:0] LEN_MIN = 8'd3;
    localparam logic [BYTE_W-1:0] LEN_MAX = 8'd5;

    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_FIRST  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SECOND = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_THIRD  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ID_LOW        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ID_HIGH       = 3'd4;

    localparam logic [BYTE_W-1:0] RST_HEADER_FIRST  = 8'd255;
    localparam logic [BYTE_W-1:0] RST_HEADER_SECOND = 8'd255;
    localparam logic [BYTE_W-1:0] RST_HEADER_THIRD  = 8'd161;
    localparam logic [BYTE_W-1:0] RST_ID_LOW        = 8'd0;
    localparam logic [BYTE_W-1:0] RST_ID_HIGH       = 8'd255;

    typedef struct packed {
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
        logic [BYTE_W-1:0] header_third;
        logic [BYTE_W-1:0] id_low;
        logic [BYTE_W-1:0] id_high;
    } cfg_t;

    typedef struct packed {
        logic              frame_good;
        logic [BYTE_W-1:0] device_id;
        logic [LEN_W-1:0]  length_field;
        logic [BYTE_W-1:0] first_data;
        logic [BYTE_W-1:0] second_data;
        logic [BYTE_W-1:0] checksum_byte;
    } result_t;

    typedef enum logic [5:0] {
        PH_WAIT_H1  = 6'b000001,
        PH_WAIT_H2  = 6'b000010,
        PH_WAIT_H3  = 6'b000100,
        PH_WAIT_ID  = 6'b001000,
        PH_WAIT_LEN = 6'b010000,
        PH_PAYLOAD  = 6'b100000
    } phase_t;

endpackage

// ----- hdl/shfr_cfg_regs.sv -----
// Configuration register file of the frame receiver.
module shfr_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [shfr_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [shfr_pkg::BYTE_W-1:0]      wr_data,
    output shfr_pkg::cfg_t                   cfg
);
    import shfr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                REG_HEADER_FIRST:  cfg_next.header_first  = wr_data;
                REG_HEADER_SECOND: cfg_next.header_second = wr_data;
                REG_HEADER_THIRD:  cfg_next.header_third  = wr_data;
                REG_ID_LOW:        cfg_next.id_low        = wr_data;
                REG_ID_HIGH:       cfg_next.id_high       = wr_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_first  <= RST_HEADER_FIRST;
            cfg_reg.header_second <= RST_HEADER_SECOND;
            cfg_reg.header_third  <= RST_HEADER_THIRD;
            cfg_reg.id_low        <= RST_ID_LOW;
            cfg_reg.id_high       <= RST_ID_HIGH;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/shfr_parser.sv -----
// Frame parser: header match, ID and length checks, running checksum.
module shfr_parser (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  shfr_pkg::cfg_t             cfg,
    input  logic                       byte_fire,
    input  logic [shfr_pkg::BYTE_W-1:0] rx_byte,
    output logic                       emit,
    output shfr_pkg::result_t          result
);
    import shfr_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [1:0]         count_reg, count_next;
    logic [BYTE_W-1:0]  sum_reg, sum_next;
    logic [BYTE_W-1:0]  id_reg, id_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [BYTE_W-1:0]  data_one_reg, data_one_next;
    logic [BYTE_W-1:0]  data_two_reg, data_two_next;
    logic [BYTE_W-1:0]  sum_plus;

    assign sum_plus = sum_reg + rx_byte;

    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        id_next       = id_reg;
        len_next      = len_reg;
        data_one_next = data_one_reg;
        data_two_next = data_two_reg;
        emit          = 1'b0;
        case (phase_reg)
            PH_WAIT_H2: begin
                // a repeated first header restarts the frame
                if (rx_byte == cfg.header_second) begin
                    phase_next = PH_WAIT_H3;
                end else if (rx_byte == cfg.header_first) begin
                    phase_next = PH_WAIT_H2;
                    count_next = 2'd0;
                end else begin
                    phase_next = PH_WAIT_H1;
                    count_next = 2'd0;
                end
            end
            PH_WAIT_H3: begin
                if (rx_byte == cfg.header_third) begin
                    sum_next   = rx_byte;
                    phase_next = PH_WAIT_ID;
                end else begin
                    phase_next = PH_WAIT_H1;
                    count_next = 2'd0;
                end
            end
            PH_WAIT_ID: begin
                if (rx_byte >= cfg.id_low && rx_byte <= cfg.id_high) begin
                    id_next    = rx_byte;
                    sum_next   = sum_plus;
                    phase_next = PH_WAIT_LEN;
                end else begin
                    phase_next = PH_WAIT_H1;
                    count_next = 2'd0;
                end
            end
            PH_WAIT_LEN: begin
                if (rx_byte inside {[LEN_MIN:LEN_MAX]}) begin
                    len_next   = rx_byte[LEN_W-1:0];
                    sum_next   = sum_plus;
                    count_next = 2'd0;
                    phase_next = PH_PAYLOAD;
                end else begin
                    phase_next = PH_WAIT_H1;
                    count_next = 2'd0;
                end
            end
            PH_PAYLOAD: begin
                if (count_reg == 2'd0) begin
                    data_one_next = rx_byte;
                    sum_next      = sum_plus;
                    count_next    = 2'd1;
                end else if (count_reg == 2'd1) begin
                    data_two_next = rx_byte;
                    sum_next      = sum_plus;
                    count_next    = 2'd2;
                end else begin
                    emit       = 1'b1;
                    phase_next = PH_WAIT_H1;
                    count_next = 2'd0;
                end
            end
            default: begin
                if (rx_byte == cfg.header_first) begin
                    phase_next = PH_WAIT_H2;
                end else begin
                    phase_next = PH_WAIT_H1;
                end
                count_next = 2'd0;
            end
        endcase
    end

    always_comb begin
        result.frame_good    = (~sum_reg == rx_byte);
        result.device_id     = id_reg;
        result.length_field  = len_reg;
        result.first_data    = data_one_reg;
        result.second_data   = data_two_reg;
        result.checksum_byte = rx_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_WAIT_H1;
            count_reg    <= 2'd0;
            sum_reg      <= '0;
            id_reg       <= '0;
            len_reg      <= '0;
            data_one_reg <= '0;
            data_two_reg <= '0;
        end else if (byte_fire) begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            id_reg       <= id_next;
            len_reg      <= len_next;
            data_one_reg <= data_one_next;
            data_two_reg <= data_two_next;
        end
    end

endmodule

// ----- hdl/sync_header_frame_receiver_unit.sv -----
// Top level of the sync-header frame receiver: input stage, parser, result register.
//
//  channel  | direction | handshake              | payload
//  s_       | in        | s_valid / s_ready      | s_rx_byte[7:0]
//  m_       | out       | m_valid / m_ready      | frame_good, id, length, data, checksum
//  cfg_     | in        | cfg_valid / cfg_ready  | cfg_index[2:0], cfg_data[7:0]
//
//  One byte a cycle sustained while no result is stalled at m_; a beat passes from s_
//  to m_ through the input register, parser logic and result register.
//  Only the last byte of a frame needs the result register, so other bytes move on
//  while a result is stalled at m_.
//  Reset (aresetn low, synchronous) empties both stages, restores the register
//  defaults and returns the parser to the first-header search.
module sync_header_frame_receiver_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [shfr_pkg::BYTE_W-1:0]      s_rx_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_frame_good,
    output logic [shfr_pkg::BYTE_W-1:0]      m_device_id,
    output logic [shfr_pkg::LEN_W-1:0]       m_length_field,
    output logic [shfr_pkg::BYTE_W-1:0]      m_first_data,
    output logic [shfr_pkg::BYTE_W-1:0]      m_second_data,
    output logic [shfr_pkg::BYTE_W-1:0]      m_checksum_byte,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [shfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [shfr_pkg::BYTE_W-1:0]      cfg_data
);
    import shfr_pkg::*;

    cfg_t              cfg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    logic              emit;
    result_t           result;
    logic              advance;

    assign cfg_ready = 1'b1;

    shfr_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    shfr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .byte_fire (advance),
        .rx_byte   (in_byte_reg),
        .emit      (emit),
        .result    (result)
    );

    // hold the beat only when it ends a frame and the result slot is still full
    assign advance = in_valid_reg && (!emit || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_frame_good    = out_reg.frame_good;
    assign m_device_id     = out_reg.device_id;
    assign m_length_field  = out_reg.length_field;
    assign m_first_data    = out_reg.first_data;
    assign m_second_data   = out_reg.second_data;
    assign m_checksum_byte = out_reg.checksum_byte;

    // a frame end never overwrites a result that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && emit && out_valid_reg && !m_ready))
        else $error("result overwritten while stalled");

    // a stalled result keeps its fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result changed");

    // a delivered length is always one the parser accepts
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.length_field == LEN_MIN[LEN_W-1:0]
            || out_reg.length_field == 3'd4
            || out_reg.length_field == LEN_MAX[LEN_W-1:0]))
        else $error("length field out of range");

endmodule

// ----- tb/sv/tb_sync_header_frame_receiver_unit.sv -----
// Testbench for the sync-header frame receiver: byte driver, result monitor and frame predictor.
module tb_sync_header_frame_receiver_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import shfr_pkg::*;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [BYTE_W-1:0]      s_rx_byte = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_frame_good;
    logic [BYTE_W-1:0]      m_device_id;
    logic [LEN_W-1:0]       m_length_field;
    logic [BYTE_W-1:0]      m_first_data;
    logic [BYTE_W-1:0]      m_second_data;
    logic [BYTE_W-1:0]      m_checksum_byte;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]      cfg_data = '0;

    sync_header_frame_receiver_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_good   (m_frame_good),
        .m_device_id    (m_device_id),
        .m_length_field (m_length_field),
        .m_first_data   (m_first_data),
        .m_second_data  (m_second_data),
        .m_checksum_byte(m_checksum_byte),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Register copy and parser state of the predictor
    cfg_t              live_cfg;
    phase_t            sync_phase;
    logic [1:0]        payload_seen;
    logic [BYTE_W-1:0] frame_sum;
    logic [BYTE_W-1:0] kept_id;
    logic [BYTE_W-1:0] kept_len;
    logic [BYTE_W-1:0] kept_d1;
    logic [BYTE_W-1:0] kept_d2;

    result_t           frames_due[$];
    logic [BYTE_W-1:0] byte_backlog[$];
    logic [BYTE_W-1:0] frame_buf[$];
    int                errors = 0;

    int                send_gap = 0;
    bit                send_quiet = 1'b0;
    int                stall_left = 0;
    bit                recv_quiet = 1'b0;
    result_t           want;

    task automatic note_mismatch(input string msg);
        errors++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function automatic int gap_len(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void restart_search();
        sync_phase   = PH_WAIT_H1;
        payload_seen = '0;
    endfunction

    // Advance the frame search by one byte; queue a result on the checksum byte
    function automatic void advance_parser(input logic [BYTE_W-1:0] b);
        result_t r;
        case (sync_phase)
            PH_WAIT_H2: begin
                // a header_second match wins over a new header_first
                if (b == live_cfg.header_second) begin
                    sync_phase = PH_WAIT_H3;
                end else if (b == live_cfg.header_first) begin
                    sync_phase   = PH_WAIT_H2;
                    payload_seen = '0;
                end else begin
                    restart_search();
                end
            end
            PH_WAIT_H3: begin
                if (b == live_cfg.header_third) begin
                    frame_sum  = b;
                    sync_phase = PH_WAIT_ID;
                end else begin
                    restart_search();
                end
            end
            PH_WAIT_ID: begin
                if (b >= live_cfg.id_low && b <= live_cfg.id_high) begin
                    kept_id    = b;
                    frame_sum  = frame_sum + b;
                    sync_phase = PH_WAIT_LEN;
                end else begin
                    restart_search();
                end
            end
            PH_WAIT_LEN: begin
                if (b >= LEN_MIN && b <= LEN_MAX) begin
                    kept_len     = b;
                    frame_sum    = frame_sum + b;
                    payload_seen = '0;
                    sync_phase   = PH_PAYLOAD;
                end else begin
                    restart_search();
                end
            end
            PH_PAYLOAD: begin
                if (payload_seen == 2'd0) begin
                    kept_d1      = b;
                    frame_sum    = frame_sum + b;
                    payload_seen = 2'd1;
                end else if (payload_seen == 2'd1) begin
                    kept_d2      = b;
                    frame_sum    = frame_sum + b;
                    payload_seen = 2'd2;
                end else begin
                    r.frame_good    = (b == ~frame_sum);
                    r.device_id     = kept_id;
                    r.length_field  = kept_len[LEN_W-1:0];
                    r.first_data    = kept_d1;
                    r.second_data   = kept_d2;
                    r.checksum_byte = b;
                    frames_due.push_back(r);
                    restart_search();
                end
            end
            default: begin
                if (b == live_cfg.header_first) begin
                    sync_phase   = PH_WAIT_H2;
                    payload_seen = '0;
                end else begin
                    restart_search();
                end
            end
        endcase
    endfunction

    // Byte driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) advance_parser(s_rx_byte);
            if (s_valid && !s_ready) begin
                // hold the beat until taken
            end else if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (byte_backlog.size() != 0) begin
                s_rx_byte <= byte_backlog.pop_front();
                s_valid   <= 1'b1;
                if ($urandom_range(0, 199) == 0) send_quiet = !send_quiet;
                send_gap = gap_len(send_quiet);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [BYTE_W-1:0] exp_v,
                               input logic [BYTE_W-1:0] got_v);
        if (got_v !== exp_v)
            note_mismatch($sformatf("%s: expected %0h, got %0h", name, exp_v, got_v));
    endtask

    // Result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (frames_due.size() == 0) begin
                    note_mismatch("result beat with no frame pending");
                end else begin
                    want = frames_due.pop_front();
                    check_field("frame_good", want.frame_good, m_frame_good);
                    check_field("device_id", want.device_id, m_device_id);
                    check_field("length_field", want.length_field, m_length_field);
                    check_field("first_data", want.first_data, m_first_data);
                    check_field("second_data", want.second_data, m_second_data);
                    check_field("checksum_byte", want.checksum_byte, m_checksum_byte);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 199) == 0) recv_quiet = !recv_quiet;
                if ((m_valid && m_ready) || $urandom_range(0, 7) == 0)
                    stall_left = gap_len(recv_quiet);
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            REG_HEADER_FIRST:  live_cfg.header_first  = val;
            REG_HEADER_SECOND: live_cfg.header_second = val;
            REG_HEADER_THIRD:  live_cfg.header_third  = val;
            REG_ID_LOW:        live_cfg.id_low        = val;
            REG_ID_HIGH:       live_cfg.id_high       = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input cfg_t c);
        write_reg(REG_HEADER_FIRST, c.header_first);
        write_reg(REG_HEADER_SECOND, c.header_second);
        write_reg(REG_HEADER_THIRD, c.header_third);
        write_reg(REG_ID_LOW, c.id_low);
        write_reg(REG_ID_HIGH, c.id_high);
    endtask

    // Wait for the backlog and all pending frames to drain, then let the pipeline empty
    task automatic settle();
        do @(negedge aclk);
        while (byte_backlog.size() != 0 || s_valid || frames_due.size() != 0);
        repeat (6) @(posedge aclk);
    endtask

    task automatic build_frame(input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] ln,
                               input logic [BYTE_W-1:0] d1, input logic [BYTE_W-1:0] d2,
                               input bit bad_ck);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] ck;
        sum = live_cfg.header_third + id + ln + d1 + d2;
        ck  = ~sum;
        if (bad_ck) ck = ck ^ $urandom_range(1, 255);
        frame_buf.delete();
        frame_buf.push_back(live_cfg.header_first);
        frame_buf.push_back(live_cfg.header_second);
        frame_buf.push_back(live_cfg.header_third);
        frame_buf.push_back(id);
        frame_buf.push_back(ln);
        frame_buf.push_back(d1);
        frame_buf.push_back(d2);
        frame_buf.push_back(ck);
    endtask

    task automatic flush_frame();
        foreach (frame_buf[i]) byte_backlog.push_back(frame_buf[i]);
    endtask

    function automatic logic [BYTE_W-1:0] noise_byte();
        case ($urandom_range(0, 5))
            0: return live_cfg.header_first;
            1: return live_cfg.header_second;
            2: return live_cfg.header_third;
            default: return $urandom;
        endcase
    endfunction

    task automatic fill_random(input int target);
        int                count;
        int                r;
        int                p;
        logic [BYTE_W-1:0] id;
        count = 0;
        while (count < target) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                p = $urandom_range(1, 6);
                repeat (p) byte_backlog.push_back(noise_byte());
                count += p;
            end else begin
                if (live_cfg.id_low <= live_cfg.id_high) begin
                    case ($urandom_range(0, 9))
                        0: id = live_cfg.id_low;
                        1: id = live_cfg.id_high;
                        default: id = $urandom_range(live_cfg.id_high, live_cfg.id_low);
                    endcase
                end else begin
                    id = $urandom;
                end
                build_frame(id, $urandom_range(LEN_MAX, LEN_MIN), $urandom, $urandom,
                            $urandom_range(0, 4) == 0);
                // spoil about a quarter of the frames: cut them short or damage one byte
                if (r >= 80) begin
                    if ($urandom_range(0, 1) == 0) begin
                        p = $urandom_range(1, 7);
                        while (frame_buf.size() > p) void'(frame_buf.pop_back());
                    end else begin
                        p = $urandom_range(0, 7);
                        case (p)
                            3: frame_buf[3] = ($urandom_range(0, 1) == 0) ?
                                              live_cfg.id_low - 1 : live_cfg.id_high + 1;
                            4: frame_buf[4] = ($urandom_range(0, 1) == 0) ?
                                              LEN_MIN - 1 : LEN_MAX + 1;
                            default: frame_buf[p] = $urandom;
                        endcase
                    end
                end
                count += frame_buf.size();
                flush_frame();
            end
        end
    endtask

    initial begin
        cfg_t              next;
        logic [BYTE_W-1:0] restart_seq[13];
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        int                k;

        live_cfg = '{header_first: RST_HEADER_FIRST, header_second: RST_HEADER_SECOND,
                     header_third: RST_HEADER_THIRD, id_low: RST_ID_LOW,
                     id_high: RST_ID_HIGH};
        restart_search();
        frame_sum = '0;
        kept_id   = '0;
        kept_len  = '0;
        kept_d1   = '0;
        kept_d2   = '0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Defaults: a good frame at the top extremes, a bad checksum at the bottom ones
        apply_settings(live_cfg);
        build_frame(8'hFF, LEN_MAX, 8'hFF, 8'hFF, 1'b0);
        flush_frame();
        build_frame(8'h00, LEN_MIN, 8'h00, 8'h00, 1'b1);
        flush_frame();
        settle();

        // Header restart, length miss, third-header miss and ID range miss
        next = '{header_first: 8'h55, header_second: 8'hAA, header_third: 8'h00,
                 id_low: 8'h10, id_high: 8'h20};
        apply_settings(next);
        restart_seq = '{8'h55, 8'h55, 8'hAA, 8'h00, 8'h10, 8'h02,
                        8'h55, 8'hAA, 8'h55,
                        8'h55, 8'hAA, 8'h00, 8'h21};
        foreach (restart_seq[i]) byte_backlog.push_back(restart_seq[i]);
        settle();

        for (int ph = 0; ph < 9; ph++) begin
            next.header_first  = $urandom;
            next.header_second = $urandom;
            next.header_third  = $urandom;
            a = $urandom;
            b = $urandom;
            next.id_low  = (a < b) ? a : b;
            next.id_high = (a < b) ? b : a;
            case (ph)
                0: begin
                    next.id_low  = 8'h00;
                    next.id_high = 8'hFF;
                end
                1: next.header_second = next.header_first;
                2: next = '{default: 8'h00};
                3: next = '{default: 8'hFF};
                4: begin
                    // empty ID range
                    next.id_low  = (a < b) ? b : a;
                    next.id_high = (a < b) ? a : b;
                    if (next.id_low == next.id_high) next.id_low = next.id_high + 1;
                end
                5: next.id_high = next.id_low;
                6: next.header_third = next.header_second;
                default: ;
            endcase
            apply_settings(next);
            if (ph == 0) begin
                // spare indexes must leave every register untouched
                for (k = REG_ID_HIGH + 1; k <= {CFG_INDEX_W{1'b1}}; k++)
                    write_reg(k, $urandom);
            end
            fill_random((ph == 4) ? 80 : 170);
            settle();
        end

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
